[rtl/hpa_pkg.sv]
// ----------------------------------------------------------------------------
// hpa_pkg
// shared types and codes of the handle pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package hpa_pkg;

  localparam int unsigned HandleW = 8;
  localparam int unsigned HandleSpace = 256;
  localparam int unsigned CountW = 9;

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [CountW-1:0]  count_t;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_TRY_ALLOC = 2'd1,
    CMD_DEALLOC   = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

endpackage

`default_nettype wire

[rtl/hpa_if.sv]
// ----------------------------------------------------------------------------
// hpa_req_if / hpa_rsp_if
// valid/ready channels carrying request and response beats
// ----------------------------------------------------------------------------
`default_nettype none

interface hpa_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] handle_in;

  modport source (output valid, output cmd, output handle_in, input ready);
  modport sink (input valid, input cmd, input handle_in, output ready);
endinterface

interface hpa_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] handle_out;
  logic [1:0] status;

  modport source (output valid, output handle_out, output status, input ready);
  modport sink (input valid, input handle_out, input status, output ready);
endinterface

`default_nettype wire

[rtl/hpa_ram.sv]
// ----------------------------------------------------------------------------
// hpa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/handle_pool_allocator.sv]
// ----------------------------------------------------------------------------
// handle_pool_allocator
// handle allocator with a fifo free list and an in-use bitmap in rams
// response: a request beat is captured, then executed in the exec state once the
//   response slot is free, which registers its response beat; a new request is taken
//   only in idle, after the read-modify-write (read, then update) of the rams retires
// reset: head, tail, count and fresh counter clear; the bitmap needs no sweep,
//   entries at or above the fresh counter read as clear; ready right away
// ----------------------------------------------------------------------------
`default_nettype none

module handle_pool_allocator
  import hpa_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 256
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  hpa_req_if.sink   req_i,
  hpa_rsp_if.source rsp_o
);

  // pool actually in use is bounded by the 8-bit handle space
  localparam int unsigned Capacity = (POOL_SIZE < HandleSpace) ? POOL_SIZE : HandleSpace;
  localparam count_t CapacityC = count_t'(Capacity);

  fsm_e    state_q, state_d;
  handle_t head_q, head_d;
  handle_t tail_q, tail_d;
  count_t  count_q, count_d;
  count_t  fresh_q, fresh_d;

  // captured request beat
  cmd_e    cmd_q;
  handle_t hin_q;

  // response register
  logic    rsp_valid_q, rsp_valid_d;
  handle_t hout_q, hout_d;
  status_e status_q, status_d;

  // ram ports
  logic    map_we;
  handle_t map_waddr;
  logic    map_wdata;
  logic    map_rdata;
  logic    fl_we;
  handle_t fl_rdata;

  logic req_fire;
  logic exec_go;
  logic hin_known;

  assign req_i.ready = (state_q == FSM_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  // the update retires only once the response slot is free
  assign exec_go     = (state_q == FSM_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // a bitmap entry never written lies at or above the fresh counter
  assign hin_known = ({1'b0, hin_q} < fresh_q) && map_rdata;

  // in-use bitmap: read at the request handle, written at the chosen handle
  hpa_ram #(
    .Width (1),
    .Depth (HandleSpace)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (req_fire),
    .raddr_i (req_i.handle_in),
    .rdata_o (map_rdata)
  );

  // free list queue storage: read at head, written at tail
  hpa_ram #(
    .Width (HandleW),
    .Depth (HandleSpace)
  ) u_fl_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (tail_q),
    .wdata_i (hin_q),
    .re_i    (req_fire),
    .raddr_i (head_q),
    .rdata_o (fl_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (req_fire) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (exec_go) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // command decode and state update
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    map_we      = 1'b0;
    map_waddr   = hin_q;
    map_wdata   = 1'b0;
    fl_we       = 1'b0;
    hout_d      = hout_q;
    status_d    = status_q;
    rsp_valid_d = rsp_valid_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    if (exec_go) begin
      rsp_valid_d = 1'b1;
      hout_d      = '0;
      status_d    = ST_OK;
      case (cmd_q)
        CMD_ALLOC, CMD_TRY_ALLOC: begin
          if (count_q != '0) begin
            // oldest freed handle first
            hout_d    = fl_rdata;
            map_we    = 1'b1;
            map_waddr = fl_rdata;
            map_wdata = 1'b1;
            head_d    = head_q + handle_t'(1);
            count_d   = count_q - count_t'(1);
          end else if (cmd_q == CMD_TRY_ALLOC) begin
            status_d = ST_EMPTY;
          end else if (fresh_q < CapacityC) begin
            // issue a never-used handle
            hout_d    = fresh_q[HandleW-1:0];
            map_we    = 1'b1;
            map_waddr = fresh_q[HandleW-1:0];
            map_wdata = 1'b1;
            fresh_d   = fresh_q + count_t'(1);
          end else begin
            status_d = ST_EXHAUSTED;
          end
        end
        CMD_DEALLOC: begin
          if (!hin_known) begin
            status_d = ST_UNKNOWN;
          end else begin
            map_we    = 1'b1;
            map_waddr = hin_q;
            map_wdata = 1'b0;
            fl_we     = 1'b1;
            tail_d    = tail_q + handle_t'(1);
            count_d   = count_q + count_t'(1);
          end
        end
        default: begin
          // unused command: no state change, zero response
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      fresh_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q <= cmd_e'(req_i.cmd);
      hin_q <= req_i.handle_in;
    end
    hout_q   <= hout_d;
    status_q <= status_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.handle_out = hout_q;
  assign rsp_o.status     = status_q;

endmodule

`default_nettype wire
